FILE: rtl/qsvt_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion placement transform package
// Shared widths, register indexes, reset values and the structures that
// pass between the stages of the vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package qsvt_pkg;

   localparam int QuatWidth     = 16;
   localparam int CoordWidth    = 32;
   localparam int ScaleWidth    = 16;
   localparam int ColorWidth    = 32;
   localparam int ByteWidth     = 8;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   localparam int ProdWidth   = 2 * QuatWidth;
   localparam int EntryWidth  = 34;
   localparam int ScaledWidth = 50;
   localparam int LoWidth     = 25;
   localparam int HiWidth     = ScaledWidth - LoWidth;
   localparam int LoProdWidth = CoordWidth + LoWidth + 1;
   localparam int HiProdWidth = CoordWidth + HiWidth;
   localparam int SumWidth    = 84;
   localparam int FracShift   = 36;
   localparam int QuotWidth   = SumWidth - FracShift;
   localparam int MatrixSize  = 9;

   localparam int NormOne = 1 << 28;
   localparam logic [EntryWidth-1:0] NormTol = EntryWidth'(NormOne / 500);
   localparam logic [SumWidth-1:0] RoundHalf = SumWidth'(1) << (FracShift - 1);

   localparam logic [QuatWidth-1:0]  QuatWReset  = 16'd16384;
   localparam logic [ScaleWidth-1:0] ScaleReset  = 16'd256;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_QUAT_X,
      CSR_QUAT_Y,
      CSR_QUAT_Z,
      CSR_QUAT_W,
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_SCALE
   } csr_index_type;

   typedef struct packed {
      logic [QuatWidth-1:0]  quat_x;
      logic [QuatWidth-1:0]  quat_y;
      logic [QuatWidth-1:0]  quat_z;
      logic [QuatWidth-1:0]  quat_w;
      logic [CoordWidth-1:0] origin_x;
      logic [CoordWidth-1:0] origin_y;
      logic [CoordWidth-1:0] origin_z;
      logic [ScaleWidth-1:0] scale;
   } qsvt_cfg_type;

   // Entry k*3+r of m is the matrix entry a[k][r] already multiplied by scale.
   typedef struct packed {
      logic [CoordWidth-1:0]                   vertex_x;
      logic [CoordWidth-1:0]                   vertex_y;
      logic [CoordWidth-1:0]                   vertex_z;
      logic [ColorWidth-1:0]                   color;
      logic                                    bad;
      logic [MatrixSize-1:0][ScaledWidth-1:0]  m;
   } qsvt_rot_out_type;

endpackage

`default_nettype wire

FILE: rtl/qsvt_csr.sv
// ----------------------------------------------------------------------------
// Quaternion placement transform configuration registers
// Holds the quaternion, origin and scale written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module qsvt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [qsvt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [qsvt_pkg::CsrDataWidth-1:0]    csr_write_data,
   output qsvt_pkg::qsvt_cfg_type               cfg
);

   qsvt_pkg::qsvt_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quat_x   <= '0;
         cfg_ff.quat_y   <= '0;
         cfg_ff.quat_z   <= '0;
         cfg_ff.quat_w   <= qsvt_pkg::QuatWReset;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.scale    <= qsvt_pkg::ScaleReset;
      end else if (csr_write_enable) begin
         unique case (qsvt_pkg::csr_index_type'(csr_index))
            qsvt_pkg::CSR_QUAT_X: begin
               cfg_ff.quat_x <= csr_write_data[qsvt_pkg::QuatWidth-1:0];
            end
            qsvt_pkg::CSR_QUAT_Y: begin
               cfg_ff.quat_y <= csr_write_data[qsvt_pkg::QuatWidth-1:0];
            end
            qsvt_pkg::CSR_QUAT_Z: begin
               cfg_ff.quat_z <= csr_write_data[qsvt_pkg::QuatWidth-1:0];
            end
            qsvt_pkg::CSR_QUAT_W: begin
               cfg_ff.quat_w <= csr_write_data[qsvt_pkg::QuatWidth-1:0];
            end
            qsvt_pkg::CSR_ORIGIN_X: begin
               cfg_ff.origin_x <= csr_write_data[qsvt_pkg::CoordWidth-1:0];
            end
            qsvt_pkg::CSR_ORIGIN_Y: begin
               cfg_ff.origin_y <= csr_write_data[qsvt_pkg::CoordWidth-1:0];
            end
            qsvt_pkg::CSR_ORIGIN_Z: begin
               cfg_ff.origin_z <= csr_write_data[qsvt_pkg::CoordWidth-1:0];
            end
            qsvt_pkg::CSR_SCALE: begin
               cfg_ff.scale <= csr_write_data[qsvt_pkg::ScaleWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/qsvt_rot.sv
// ----------------------------------------------------------------------------
// Quaternion placement transform rotation stages
// Three pipeline stages: quaternion products, matrix entries with the unit
// test, and multiplication of every entry by the scale.
// ----------------------------------------------------------------------------
`default_nettype none

module qsvt_rot (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qsvt_pkg::qsvt_cfg_type               cfg,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [qsvt_pkg::CoordWidth-1:0]      vertex_x,
   input  logic [qsvt_pkg::CoordWidth-1:0]      vertex_y,
   input  logic [qsvt_pkg::CoordWidth-1:0]      vertex_z,
   input  logic [qsvt_pkg::ColorWidth-1:0]      packed_color,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output qsvt_pkg::qsvt_rot_out_type           out_data
);

   localparam int EW = qsvt_pkg::EntryWidth;
   localparam int PW = qsvt_pkg::ProdWidth;
   localparam int MS = qsvt_pkg::MatrixSize;
   localparam logic signed [EW-1:0] One = EW'(qsvt_pkg::NormOne);

   function automatic logic signed [EW-1:0] ext(input logic signed [PW-1:0] p);
      return EW'(p);
   endfunction

   logic signed [qsvt_pkg::QuatWidth-1:0] qx, qy, qz, qw;

   logic ready1, ready2, ready3;
   logic v1_ff, v2_ff, v3_ff;

   logic [qsvt_pkg::CoordWidth-1:0] vx1_ff, vy1_ff, vz1_ff;
   logic [qsvt_pkg::CoordWidth-1:0] vx2_ff, vy2_ff, vz2_ff;
   logic [qsvt_pkg::CoordWidth-1:0] vx3_ff, vy3_ff, vz3_ff;
   logic [qsvt_pkg::ColorWidth-1:0] color1_ff, color2_ff, color3_ff;

   logic signed [PW-1:0] xx_in, yy_in, zz_in, ww_in, xy_in, xz_in, xw_in, yz_in, yw_in, zw_in;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, xz_ff, xw_ff, yz_ff, yw_ff, zw_ff;

   logic signed [EW-1:0] a_in [MS];
   logic signed [EW-1:0] a_ff [MS];
   logic signed [EW-1:0] norm_diff;
   logic [EW-1:0]        norm_mag;
   logic                 bad_in, bad2_ff, bad3_ff;

   logic signed [EW+qsvt_pkg::ScaleWidth:0] scaled [MS];
   logic [qsvt_pkg::ScaledWidth-1:0]        m_in [MS];
   logic [qsvt_pkg::ScaledWidth-1:0]        m_ff [MS];

   assign qx = $signed(cfg.quat_x);
   assign qy = $signed(cfg.quat_y);
   assign qz = $signed(cfg.quat_z);
   assign qw = $signed(cfg.quat_w);

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      xx_in = qx * qx;
      yy_in = qy * qy;
      zz_in = qz * qz;
      ww_in = qw * qw;
      xy_in = qx * qy;
      xz_in = qx * qz;
      xw_in = qx * qw;
      yz_in = qy * qz;
      yw_in = qy * qw;
      zw_in = qz * qw;
   end

   always_comb begin
      a_in[0] = One - ((ext(yy_ff) + ext(zz_ff)) <<< 1);
      a_in[1] = (ext(xy_ff) + ext(zw_ff)) <<< 1;
      a_in[2] = (ext(xz_ff) - ext(yw_ff)) <<< 1;
      a_in[3] = (ext(xy_ff) - ext(zw_ff)) <<< 1;
      a_in[4] = One - ((ext(xx_ff) + ext(zz_ff)) <<< 1);
      a_in[5] = (ext(yz_ff) + ext(xw_ff)) <<< 1;
      a_in[6] = (ext(xz_ff) + ext(yw_ff)) <<< 1;
      a_in[7] = (ext(yz_ff) - ext(xw_ff)) <<< 1;
      a_in[8] = One - ((ext(xx_ff) + ext(yy_ff)) <<< 1);
      norm_diff = ext(xx_ff) + ext(yy_ff) + ext(zz_ff) + ext(ww_ff) - One;
      norm_mag  = norm_diff[EW-1] ? EW'(-norm_diff) : EW'(norm_diff);
      bad_in    = (norm_mag > qsvt_pkg::NormTol) || (cfg.scale == '0);
   end

   always_comb begin
      for (int i = 0; i < MS; i++) begin
         scaled[i] = a_ff[i] * $signed({1'b0, cfg.scale});
         m_in[i]   = scaled[i][qsvt_pkg::ScaledWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         vx1_ff    <= vertex_x;
         vy1_ff    <= vertex_y;
         vz1_ff    <= vertex_z;
         color1_ff <= packed_color;
         xx_ff     <= xx_in;
         yy_ff     <= yy_in;
         zz_ff     <= zz_in;
         ww_ff     <= ww_in;
         xy_ff     <= xy_in;
         xz_ff     <= xz_in;
         xw_ff     <= xw_in;
         yz_ff     <= yz_in;
         yw_ff     <= yw_in;
         zw_ff     <= zw_in;
      end
      if (ready2) begin
         vx2_ff    <= vx1_ff;
         vy2_ff    <= vy1_ff;
         vz2_ff    <= vz1_ff;
         color2_ff <= color1_ff;
         bad2_ff   <= bad_in;
         for (int i = 0; i < MS; i++) a_ff[i] <= a_in[i];
      end
      if (ready3) begin
         vx3_ff    <= vx2_ff;
         vy3_ff    <= vy2_ff;
         vz3_ff    <= vz2_ff;
         color3_ff <= color2_ff;
         bad3_ff   <= bad2_ff;
         for (int i = 0; i < MS; i++) m_ff[i] <= m_in[i];
      end
   end

   always_comb begin
      out_data.vertex_x = vx3_ff;
      out_data.vertex_y = vy3_ff;
      out_data.vertex_z = vz3_ff;
      out_data.color    = color3_ff;
      out_data.bad      = bad3_ff;
      for (int i = 0; i < MS; i++) out_data.m[i] = m_ff[i];
   end

   assign out_valid = v3_ff;

endmodule

`default_nettype wire

FILE: rtl/qsvt_mac.sv
// ----------------------------------------------------------------------------
// Quaternion placement transform accumulate stages
// Four pipeline stages: split partial products of vertex by scaled entry,
// product assembly, partial sums with the origin, and the final sum with
// rounding, saturation and the color split into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsvt_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qsvt_pkg::qsvt_cfg_type               cfg,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  qsvt_pkg::qsvt_rot_out_type           in_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_x,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_y,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_z,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_red,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_green,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_blue,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_alpha,
   output logic                                 rsp_overflow,
   output logic                                 rsp_bad_placement
);

   localparam int SW = qsvt_pkg::SumWidth;
   localparam int LW = qsvt_pkg::LoWidth;
   localparam int MW = qsvt_pkg::ScaledWidth;
   localparam int CW = qsvt_pkg::CoordWidth;
   localparam int MS = qsvt_pkg::MatrixSize;

   logic ready4, ready5, ready6, ready7;
   logic v4_ff, v5_ff, v6_ff, v7_ff;

   logic [qsvt_pkg::ColorWidth-1:0] color4_ff, color5_ff, color6_ff;
   logic                            bad4_ff, bad5_ff, bad6_ff;

   logic signed [CW-1:0] vtx [3];
   logic signed [CW-1:0] origin [3];

   logic signed [qsvt_pkg::LoProdWidth-1:0] lo_in [MS];
   logic signed [qsvt_pkg::LoProdWidth-1:0] lo_ff [MS];
   logic signed [qsvt_pkg::HiProdWidth-1:0] hi_in [MS];
   logic signed [qsvt_pkg::HiProdWidth-1:0] hi_ff [MS];

   logic signed [SW-1:0] p_in [MS];
   logic signed [SW-1:0] p_ff [MS];

   logic signed [SW-1:0] s01_in [3];
   logic signed [SW-1:0] s01_ff [3];
   logic signed [SW-1:0] s2o_in [3];
   logic signed [SW-1:0] s2o_ff [3];

   logic signed [SW-1:0]                 total [3];
   logic [qsvt_pkg::QuotWidth-1:0]       quot [3];
   logic [CW-1:0]                        world_in [3];
   logic [2:0]                           sat;
   logic [CW-1:0]                        world_ff [3];
   logic                                 ovf_ff, bad7_ff;
   logic [qsvt_pkg::ByteWidth-1:0]       red_ff, green_ff, blue_ff, alpha_ff;

   assign ready7   = !v7_ff || !rsp_stall;
   assign ready6   = !v6_ff || ready7;
   assign ready5   = !v5_ff || ready6;
   assign ready4   = !v4_ff || ready5;
   assign in_ready = ready4;

   assign vtx[0]    = $signed(in_data.vertex_x);
   assign vtx[1]    = $signed(in_data.vertex_y);
   assign vtx[2]    = $signed(in_data.vertex_z);
   assign origin[0] = $signed(cfg.origin_x);
   assign origin[1] = $signed(cfg.origin_y);
   assign origin[2] = $signed(cfg.origin_z);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            lo_in[k*3+r] = vtx[k] * $signed({1'b0, in_data.m[k*3+r][LW-1:0]});
            hi_in[k*3+r] = vtx[k] * $signed(in_data.m[k*3+r][MW-1:LW]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MS; i++) begin
         p_in[i] = (SW'(hi_ff[i]) <<< LW) + SW'(lo_ff[i]);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s01_in[r] = p_ff[r] + p_ff[3+r];
         s2o_in[r] = p_ff[6+r] + ((SW'(origin[r]) <<< qsvt_pkg::FracShift)
                                  | qsvt_pkg::RoundHalf);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         total[r] = s01_ff[r] + s2o_ff[r];
         quot[r]  = total[r][SW-1:qsvt_pkg::FracShift];
         if (!quot[r][qsvt_pkg::QuotWidth-1] && (|quot[r][qsvt_pkg::QuotWidth-2:CW-1])) begin
            world_in[r] = {1'b0, {(CW-1){1'b1}}};
            sat[r]      = 1'b1;
         end else if (quot[r][qsvt_pkg::QuotWidth-1]
                      && !(&quot[r][qsvt_pkg::QuotWidth-2:CW-1])) begin
            world_in[r] = {1'b1, {(CW-1){1'b0}}};
            sat[r]      = 1'b1;
         end else begin
            world_in[r] = quot[r][CW-1:0];
            sat[r]      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (ready4) v4_ff <= in_valid;
         if (ready5) v5_ff <= v4_ff;
         if (ready6) v6_ff <= v5_ff;
         if (ready7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         color4_ff <= in_data.color;
         bad4_ff   <= in_data.bad;
         for (int i = 0; i < MS; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
      end
      if (ready5) begin
         color5_ff <= color4_ff;
         bad5_ff   <= bad4_ff;
         for (int i = 0; i < MS; i++) p_ff[i] <= p_in[i];
      end
      if (ready6) begin
         color6_ff <= color5_ff;
         bad6_ff   <= bad5_ff;
         for (int r = 0; r < 3; r++) begin
            s01_ff[r] <= s01_in[r];
            s2o_ff[r] <= s2o_in[r];
         end
      end
      if (ready7) begin
         for (int r = 0; r < 3; r++) world_ff[r] <= world_in[r];
         ovf_ff   <= |sat;
         bad7_ff  <= bad6_ff;
         red_ff   <= color6_ff[23:16];
         green_ff <= color6_ff[15:8];
         blue_ff  <= color6_ff[7:0];
         alpha_ff <= color6_ff[31:24];
      end
   end

   assign rsp_valid         = v7_ff;
   assign rsp_world_x       = world_ff[0];
   assign rsp_world_y       = world_ff[1];
   assign rsp_world_z       = world_ff[2];
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_alpha         = alpha_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_bad_placement = bad7_ff;

endmodule

`default_nettype wire

FILE: rtl/quat_scaled_vertex_transform.sv
// ----------------------------------------------------------------------------
// Quaternion scaled vertex transform
// Rotates each vertex by the configured quaternion, scales it, adds the
// origin, splits the color word and flags bad placements and saturation.
// ----------------------------------------------------------------------------
// The block takes one vertex request per clock while req_stall is low and
// returns one result per request, in order. The seven register stages are:
// quaternion products, matrix entries with the unit test, scaling of the
// entries, split vertex by entry partial products, product assembly, partial
// sums with the origin, and the final sum with rounding and saturation. Every
// stage holds its own valid bit, so empty stages fill while the result
// register waits. The user must write configuration through the csr_ port
// only while no request is in flight; the block itself does not enforce it.
`default_nettype none

module quat_scaled_vertex_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [qsvt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [qsvt_pkg::CsrDataWidth-1:0]    csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [qsvt_pkg::CoordWidth-1:0]      req_vertex_x,
   input  logic [qsvt_pkg::CoordWidth-1:0]      req_vertex_y,
   input  logic [qsvt_pkg::CoordWidth-1:0]      req_vertex_z,
   input  logic [qsvt_pkg::ColorWidth-1:0]      req_packed_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_x,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_y,
   output logic [qsvt_pkg::CoordWidth-1:0]      rsp_world_z,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_red,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_green,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_blue,
   output logic [qsvt_pkg::ByteWidth-1:0]       rsp_alpha,
   output logic                                 rsp_overflow,
   output logic                                 rsp_bad_placement
);

   qsvt_pkg::qsvt_cfg_type     cfg;
   qsvt_pkg::qsvt_rot_out_type rot_data;
   logic                       rot_valid;
   logic                       mac_ready;
   logic                       rot_ready;

   qsvt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   qsvt_rot u_rot (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_valid),
      .in_ready     (rot_ready),
      .vertex_x     (req_vertex_x),
      .vertex_y     (req_vertex_y),
      .vertex_z     (req_vertex_z),
      .packed_color (req_packed_color),
      .out_valid    (rot_valid),
      .out_ready    (mac_ready),
      .out_data     (rot_data)
   );

   qsvt_mac u_mac (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (rot_valid),
      .in_ready          (mac_ready),
      .in_data           (rot_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_world_x       (rsp_world_x),
      .rsp_world_y       (rsp_world_y),
      .rsp_world_z       (rsp_world_z),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_overflow      (rsp_overflow),
      .rsp_bad_placement (rsp_bad_placement)
   );

   assign req_stall = !rot_ready;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion scaled vertex transform testbench
// Walks a directed table of vertices across hand-picked placements, then
// streams random vertices under random placements. Each result is checked
// against a fixed-point model of rotation, scale, origin, rounding and
// saturation, while both channels idle at varying rates.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 12;
   localparam int unsigned RandomPerMode = 350;
   localparam int unsigned VerticesPerPlacement = 50;
   localparam longint UnitNorm = longint'(1) <<< 28;
   localparam logic signed [127:0] RoundBias = 128'sd34359738368;
   localparam logic signed [127:0] SatHigh = 128'sd2147483647;
   localparam logic signed [127:0] SatLow = -128'sd2147483648;

   typedef struct packed {
      logic [qsvt_pkg::CoordWidth-1:0] vertex_x;
      logic [qsvt_pkg::CoordWidth-1:0] vertex_y;
      logic [qsvt_pkg::CoordWidth-1:0] vertex_z;
      logic [qsvt_pkg::ColorWidth-1:0] packed_color;
   } vertex_req_type;

   typedef struct packed {
      logic [qsvt_pkg::CoordWidth-1:0] world_x;
      logic [qsvt_pkg::CoordWidth-1:0] world_y;
      logic [qsvt_pkg::CoordWidth-1:0] world_z;
      logic [qsvt_pkg::ByteWidth-1:0]  red;
      logic [qsvt_pkg::ByteWidth-1:0]  green;
      logic [qsvt_pkg::ByteWidth-1:0]  blue;
      logic [qsvt_pkg::ByteWidth-1:0]  alpha;
      logic                            overflow;
      logic                            bad_placement;
   } vertex_result_type;

   typedef struct packed {
      logic [7:0]        placement;
      vertex_req_type    req;
      logic              typed_world;
      logic              typed_flags;
      vertex_result_type typed;
   } directed_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   qsvt_pkg::csr_index_type csr_index = qsvt_pkg::CSR_QUAT_X;
   logic [qsvt_pkg::CsrDataWidth-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [qsvt_pkg::CoordWidth-1:0] req_vertex_x = '0;
   logic [qsvt_pkg::CoordWidth-1:0] req_vertex_y = '0;
   logic [qsvt_pkg::CoordWidth-1:0] req_vertex_z = '0;
   logic [qsvt_pkg::ColorWidth-1:0] req_packed_color = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [qsvt_pkg::CoordWidth-1:0] rsp_world_x;
   logic [qsvt_pkg::CoordWidth-1:0] rsp_world_y;
   logic [qsvt_pkg::CoordWidth-1:0] rsp_world_z;
   logic [qsvt_pkg::ByteWidth-1:0]  rsp_red;
   logic [qsvt_pkg::ByteWidth-1:0]  rsp_green;
   logic [qsvt_pkg::ByteWidth-1:0]  rsp_blue;
   logic [qsvt_pkg::ByteWidth-1:0]  rsp_alpha;
   logic rsp_overflow;
   logic rsp_bad_placement;

   qsvt_pkg::qsvt_cfg_type placement;
   qsvt_pkg::qsvt_cfg_type placement_table[$];
   directed_case_type directed_cases[$];
   vertex_result_type expected_results[$];
   vertex_result_type got_result;
   vertex_result_type want_result;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned requests_sent = 0;
   int unsigned saturated_count = 0;
   int unsigned bad_count = 0;
   int unsigned placement_loads = 0;
   int unsigned cycle_count = 0;

   quat_scaled_vertex_transform dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .req_packed_color  (req_packed_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_world_x       (rsp_world_x),
      .rsp_world_y       (rsp_world_y),
      .rsp_world_z       (rsp_world_z),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_overflow      (rsp_overflow),
      .rsp_bad_placement (rsp_bad_placement)
   );

   always #5 clock = ~clock;

   function automatic vertex_result_type transform_vertex(input qsvt_pkg::qsvt_cfg_type cfg,
                                                          input vertex_req_type req);
      longint qx, qy, qz, qw, sc;
      longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
      longint norm, dev;
      longint ent[9];
      logic signed [qsvt_pkg::CoordWidth-1:0] vtx[3];
      logic signed [qsvt_pkg::CoordWidth-1:0] org[3];
      logic [qsvt_pkg::CoordWidth-1:0] world[3];
      logic signed [127:0] acc, vw, ew;
      logic ovf;
      vertex_result_type res;
      qx = longint'($signed(cfg.quat_x));
      qy = longint'($signed(cfg.quat_y));
      qz = longint'($signed(cfg.quat_z));
      qw = longint'($signed(cfg.quat_w));
      sc = longint'(cfg.scale);
      xx = 2 * qx * qx; xy = 2 * qx * qy; xz = 2 * qx * qz; xw = 2 * qx * qw;
      yy = 2 * qy * qy; yz = 2 * qy * qz; yw = 2 * qy * qw;
      zz = 2 * qz * qz; zw = 2 * qz * qw;
      ent[0] = (UnitNorm - (yy + zz)) * sc;
      ent[1] = (xy + zw) * sc;
      ent[2] = (xz - yw) * sc;
      ent[3] = (xy - zw) * sc;
      ent[4] = (UnitNorm - (xx + zz)) * sc;
      ent[5] = (yz + xw) * sc;
      ent[6] = (xz + yw) * sc;
      ent[7] = (yz - xw) * sc;
      ent[8] = (UnitNorm - (xx + yy)) * sc;
      vtx[0] = req.vertex_x; vtx[1] = req.vertex_y; vtx[2] = req.vertex_z;
      org[0] = cfg.origin_x; org[1] = cfg.origin_y; org[2] = cfg.origin_z;
      ovf = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc = org[r];
         acc = acc <<< 36;
         for (int k = 0; k < 3; k++) begin
            vw = vtx[k];
            ew = ent[k * 3 + r];
            acc = acc + vw * ew;
         end
         acc = (acc + RoundBias) >>> 36;
         if (acc > SatHigh) begin
            world[r] = 32'h7fffffff;
            ovf = 1'b1;
         end else if (acc < SatLow) begin
            world[r] = 32'h80000000;
            ovf = 1'b1;
         end else begin
            world[r] = acc[31:0];
         end
      end
      norm = qx * qx + qy * qy + qz * qz + qw * qw;
      dev = norm - UnitNorm;
      if (dev < 0) dev = -dev;
      res.world_x = world[0];
      res.world_y = world[1];
      res.world_z = world[2];
      res.red = req.packed_color[23:16];
      res.green = req.packed_color[15:8];
      res.blue = req.packed_color[7:0];
      res.alpha = req.packed_color[31:24];
      res.overflow = ovf;
      res.bad_placement = (dev * 500 > UnitNorm) || (sc == 0);
      return res;
   endfunction

   function automatic qsvt_pkg::qsvt_cfg_type make_placement(
         input logic [15:0] qx, input logic [15:0] qy,
         input logic [15:0] qz, input logic [15:0] qw,
         input logic [31:0] ox, input logic [31:0] oy,
         input logic [31:0] oz, input logic [15:0] sc);
      qsvt_pkg::qsvt_cfg_type cfg;
      cfg.quat_x = qx; cfg.quat_y = qy; cfg.quat_z = qz; cfg.quat_w = qw;
      cfg.origin_x = ox; cfg.origin_y = oy; cfg.origin_z = oz;
      cfg.scale = sc;
      return cfg;
   endfunction

   task automatic add_placement(input qsvt_pkg::qsvt_cfg_type cfg);
      placement_table.insert(placement_table.size(), cfg);
   endtask

   function automatic logic [31:0] random_origin();
      if ($urandom_range(1) == 0)
         return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      return $urandom;
   endfunction

   function automatic qsvt_pkg::qsvt_cfg_type random_placement();
      real fx, fy, fz, fw, mag;
      int unsigned kind, scale_kind;
      qsvt_pkg::qsvt_cfg_type cfg;
      kind = $urandom_range(99);
      scale_kind = $urandom_range(9);
      fx = real'(int'($urandom_range(20000)) - 10000) / 10000.0;
      fy = real'(int'($urandom_range(20000)) - 10000) / 10000.0;
      fz = real'(int'($urandom_range(20000)) - 10000) / 10000.0;
      fw = real'(int'($urandom_range(20000)) - 10000) / 10000.0;
      mag = $sqrt(fx * fx + fy * fy + fz * fz + fw * fw);
      if (mag < 0.01) begin
         fw = 1.0;
         mag = 1.0;
      end
      cfg.quat_x = 16'(int'(fx / mag * 16384.0));
      cfg.quat_y = 16'(int'(fy / mag * 16384.0));
      cfg.quat_z = 16'(int'(fz / mag * 16384.0));
      cfg.quat_w = 16'(int'(fw / mag * 16384.0));
      if (kind >= 55 && kind < 75) begin
         cfg.quat_w = cfg.quat_w + 16'(int'($urandom_range(80)) - 40);
      end else if (kind >= 75 && kind < 95) begin
         cfg.quat_x = 16'($urandom); cfg.quat_y = 16'($urandom);
         cfg.quat_z = 16'($urandom); cfg.quat_w = 16'($urandom);
      end else if (kind >= 95) begin
         cfg.quat_x = $urandom_range(1) ? 16'h8000 : 16'h7fff;
         cfg.quat_y = $urandom_range(1) ? 16'h8000 : 16'h7fff;
         cfg.quat_z = $urandom_range(1) ? 16'h8000 : 16'h7fff;
         cfg.quat_w = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      end
      case (scale_kind) inside
         0: cfg.scale = 16'h0000;
         1: cfg.scale = 16'hffff;
         2: cfg.scale = 16'h0100;
         [3:6]: cfg.scale = 16'($urandom_range(1, 1023));
         default: cfg.scale = 16'($urandom);
      endcase
      cfg.origin_x = random_origin();
      cfg.origin_y = random_origin();
      cfg.origin_z = random_origin();
      return cfg;
   endfunction

   function automatic logic [31:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      if (pick < 60) return 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
      if (pick < 90) return $urandom;
      case ($urandom_range(4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00000001;
         3: return 32'hffffffff;
         default: return 32'h00000000;
      endcase
   endfunction

   function automatic vertex_req_type random_vertex();
      vertex_req_type req;
      req.vertex_x = random_coord();
      req.vertex_y = random_coord();
      req.vertex_z = random_coord();
      req.packed_color = $urandom;
      return req;
   endfunction

   task automatic add_case(input logic [7:0] pl, input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz, input logic [31:0] color,
                           input logic tw, input logic tf, input logic [31:0] wx,
                           input logic [31:0] wy, input logic [31:0] wz,
                           input logic ovf, input logic bad);
      directed_case_type dc;
      dc = '0;
      dc.placement = pl;
      dc.req.vertex_x = vx;
      dc.req.vertex_y = vy;
      dc.req.vertex_z = vz;
      dc.req.packed_color = color;
      dc.typed_world = tw;
      dc.typed_flags = tf;
      dc.typed.world_x = wx;
      dc.typed.world_y = wy;
      dc.typed.world_z = wz;
      dc.typed.overflow = ovf;
      dc.typed.bad_placement = bad;
      directed_cases.insert(directed_cases.size(), dc);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_placement(input qsvt_pkg::qsvt_cfg_type cfg);
      qsvt_pkg::csr_index_type idx;
      logic [31:0] junk;
      logic [qsvt_pkg::CsrDataWidth-1:0] value;
      wait_drained();
      idx = qsvt_pkg::CSR_QUAT_X;
      do begin
         junk = $urandom;
         case (idx)
            qsvt_pkg::CSR_QUAT_X:   value = {junk[31:16], cfg.quat_x};
            qsvt_pkg::CSR_QUAT_Y:   value = {junk[31:16], cfg.quat_y};
            qsvt_pkg::CSR_QUAT_Z:   value = {junk[31:16], cfg.quat_z};
            qsvt_pkg::CSR_QUAT_W:   value = {junk[31:16], cfg.quat_w};
            qsvt_pkg::CSR_ORIGIN_X: value = cfg.origin_x;
            qsvt_pkg::CSR_ORIGIN_Y: value = cfg.origin_y;
            qsvt_pkg::CSR_ORIGIN_Z: value = cfg.origin_z;
            default:                value = {junk[31:16], cfg.scale};
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= idx;
         csr_write_data <= value;
         @(posedge clock);
         idx = idx.next();
      end while (idx != qsvt_pkg::CSR_QUAT_X);
      csr_write_enable <= 1'b0;
      placement = cfg;
      placement_loads++;
   endtask

   task automatic send_vertex(input vertex_req_type req, input logic typed_world,
                              input logic typed_flags, input vertex_result_type typed);
      vertex_result_type want;
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= req.vertex_x;
      req_vertex_y <= req.vertex_y;
      req_vertex_z <= req.vertex_z;
      req_packed_color <= req.packed_color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = transform_vertex(placement, req);
      if (typed_world) begin
         want.world_x = typed.world_x;
         want.world_y = typed.world_y;
         want.world_z = typed.world_z;
      end
      if (typed_flags) begin
         want.overflow = typed.overflow;
         want.bad_placement = typed.bad_placement;
      end
      expected_results.insert(expected_results.size(), want);
      requests_sent++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_result.world_x = rsp_world_x;
            got_result.world_y = rsp_world_y;
            got_result.world_z = rsp_world_z;
            got_result.red = rsp_red;
            got_result.green = rsp_green;
            got_result.blue = rsp_blue;
            got_result.alpha = rsp_alpha;
            got_result.overflow = rsp_overflow;
            got_result.bad_placement = rsp_bad_placement;
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: result %h %h %h with no pending request",
                           rsp_world_x, rsp_world_y, rsp_world_z);
               error_count++;
            end else begin
               want_result = expected_results.pop_front();
               if (got_result !== want_result) begin
                  if (error_count < 10) begin
                     $display("ERROR: result %0d got xyz %h %h %h rgba %h %h %h %h ovf %b bad %b",
                              results_checked, got_result.world_x, got_result.world_y,
                              got_result.world_z, got_result.red, got_result.green,
                              got_result.blue, got_result.alpha, got_result.overflow,
                              got_result.bad_placement);
                     $display("       expected xyz %h %h %h rgba %h %h %h %h ovf %b bad %b",
                              want_result.world_x, want_result.world_y, want_result.world_z,
                              want_result.red, want_result.green, want_result.blue,
                              want_result.alpha, want_result.overflow,
                              want_result.bad_placement);
                  end
                  error_count++;
               end
            end
            if (rsp_overflow === 1'b1) saturated_count++;
            if (rsp_bad_placement === 1'b1) bad_count++;
            results_checked++;
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("quat_scaled_vertex_transform verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned current;
      int unsigned directed_count;
      add_placement(make_placement(16'd0, 16'd0, 16'd0, qsvt_pkg::QuatWReset,
                                   32'd0, 32'd0, 32'd0, qsvt_pkg::ScaleReset));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd16384,
                                   32'd0, 32'd0, 32'd0, 16'd512));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd16384,
                                   32'd0, 32'd0, 32'd0, 16'd128));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd16384,
                                   32'h12345678, 32'h80000000, 32'h7fffffff,
                                   16'd0));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd0,
                                   32'd0, 32'd0, 32'd0, 16'd256));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd16384,
                                   32'h7fffffff, 32'h80000000, 32'd0, 16'd256));
      add_placement(make_placement(16'd111, 16'd2, 16'd1, 16'd16400,
                                   32'd0, 32'd0, 32'd0, 16'd256));
      add_placement(make_placement(16'd111, 16'd2, 16'd2, 16'd16400,
                                   32'd0, 32'd0, 32'd0, 16'd256));
      add_placement(make_placement(16'd141, 16'd4, 16'd0, 16'd16367,
                                   32'd0, 32'd0, 32'd0, 16'd256));
      add_placement(make_placement(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                                   32'd0, 32'd0, 32'd0, 16'hffff));
      add_placement(make_placement(16'd0, 16'd0, 16'd11585, 16'd11585,
                                   32'h00010000, 32'hffff0000, 32'h00050000,
                                   16'd256));
      add_placement(make_placement(16'd11585, 16'd0, 16'd0, 16'hd2bf,
                                   32'd0, 32'd0, 32'd0, 16'd384));
      add_placement(make_placement(16'd0, 16'd0, 16'd0, 16'd16384,
                                   32'd0, 32'd0, 32'd0, 16'hffff));

      add_case(0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1, 32'h0, 32'h0, 32'h0, 0, 0);
      add_case(0, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffffffff, 1, 1,
               32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0);
      add_case(0, 32'h80000000, 32'h7fffffff, 32'hffff0000, 32'h80402010, 1, 1,
               32'h80000000, 32'h7fffffff, 32'hffff0000, 0, 0);
      add_case(0, 32'h12345678, 32'hdeadbeef, 32'h00000001, 32'h01020304, 1, 1,
               32'h12345678, 32'hdeadbeef, 32'h00000001, 0, 0);
      add_case(1, 32'h00010000, 32'hffff0000, 32'h40000000, 32'h55aa55aa, 1, 1,
               32'h00020000, 32'hfffe0000, 32'h7fffffff, 1, 0);
      add_case(1, 32'h3fffffff, 32'hc0000000, 32'h0, 32'haa55aa55, 1, 1,
               32'h7ffffffe, 32'h80000000, 32'h0, 0, 0);
      add_case(1, 32'h80000000, 32'h7fffffff, 32'h0, 32'h7f7f7f7f, 1, 1,
               32'h80000000, 32'h7fffffff, 32'h0, 1, 0);
      add_case(2, 32'h1, 32'hffffffff, 32'h3, 32'h00ff00ff, 1, 1,
               32'h1, 32'h0, 32'h2, 0, 0);
      add_case(2, 32'hfffffffd, 32'h2, 32'h7fffffff, 32'hff00ff00, 1, 1,
               32'hffffffff, 32'h1, 32'h40000000, 0, 0);
      add_case(3, 32'h7fffffff, 32'h80000000, 32'h55555555, 32'h0, 1, 1,
               32'h12345678, 32'h80000000, 32'h7fffffff, 0, 1);
      add_case(3, 32'h0, 32'h0, 32'h0, 32'hffffffff, 1, 1,
               32'h12345678, 32'h80000000, 32'h7fffffff, 0, 1);
      add_case(4, 32'h100, 32'hffffff00, 32'h7fffffff, 32'h11223344, 1, 1,
               32'h100, 32'hffffff00, 32'h7fffffff, 0, 1);
      add_case(5, 32'h0, 32'h0, 32'h5, 32'h99887766, 1, 1,
               32'h7fffffff, 32'h80000000, 32'h5, 0, 0);
      add_case(5, 32'h1, 32'hffffffff, 32'hfffffffb, 32'h0f0f0f0f, 1, 1,
               32'h7fffffff, 32'h80000000, 32'hfffffffb, 1, 0);
      add_case(6, 32'h00010000, 32'h00020000, 32'h00030000, 32'hf0f0f0f0, 0, 1,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(7, 32'h00010000, 32'h00020000, 32'h00030000, 32'h12121212, 0, 1,
               32'h0, 32'h0, 32'h0, 0, 1);
      add_case(8, 32'h00010000, 32'h00020000, 32'h00030000, 32'h34343434, 0, 1,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(9, 32'h00010000, 32'h00010000, 32'h00010000, 32'h56565656, 0, 0,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(9, 32'h1, 32'h1, 32'h1, 32'h78787878, 0, 0, 32'h0, 32'h0, 32'h0, 0, 0);
      add_case(10, 32'h00010000, 32'h0, 32'h0, 32'h9a9a9a9a, 0, 0,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(10, 32'h0, 32'h00010000, 32'h00010000, 32'hbcbcbcbc, 0, 0,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(11, 32'h00018000, 32'hfff20000, 32'h00300000, 32'hdededede, 0, 0,
               32'h0, 32'h0, 32'h0, 0, 0);
      add_case(12, 32'h1, 32'hffffffff, 32'h00800000, 32'h00000080, 0, 0,
               32'h0, 32'h0, 32'h0, 0, 0);

      placement = placement_table[0];
      current = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 25;
      rsp_idle_pct = 74;
      foreach (directed_cases[i]) begin
         if (directed_cases[i].placement != current) begin
            current = directed_cases[i].placement;
            load_placement(placement_table[current]);
         end
         send_vertex(directed_cases[i].req, directed_cases[i].typed_world,
                     directed_cases[i].typed_flags, directed_cases[i].typed);
      end
      directed_count = requests_sent;

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 74 : 0;
         rsp_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 25 : 0;
         for (int n = 0; n < RandomPerMode; n++) begin
            if (n % VerticesPerPlacement == 0) load_placement(random_placement());
            send_vertex(random_vertex(), 1'b0, 1'b0, '0);
         end
      end

      wait_drained();
      $display("Covered %0d vertex requests (%0d from the directed table) over %0d placements.",
               requests_sent, directed_count, placement_loads);
      $display("Checked %0d results: %0d saturated, %0d with a bad placement, %0d mismatches.",
               results_checked, saturated_count, bad_count, error_count);
      if (error_count == 0) begin
         $display("quat_scaled_vertex_transform verification clean");
      end else begin
         $display("quat_scaled_vertex_transform verification failed");
      end
      $finish;
   end

endmodule
